FILE: rtl/ktl_pkg.sv
// Shared types, constants and helpers for the keyword token lexer.
`default_nettype none
package ktl_pkg;
  localparam int unsigned OffsetBits = 24;
  localparam int unsigned LineBits   = 24;
  localparam int unsigned FieldBits  = 24;
  localparam int unsigned KindBits   = 6;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrBits = 2;

  localparam logic [OffsetBits-1:0] OffTop  = {OffsetBits{1'b1}};
  localparam logic [LineBits-1:0]   LineTop = {LineBits{1'b1}};

  localparam logic [KindBits-1:0] TkDot     = 6'd5;
  localparam logic [KindBits-1:0] TkSlash   = 6'd9;
  localparam logic [KindBits-1:0] TkBang    = 6'd11;
  localparam logic [KindBits-1:0] TkEqual   = 6'd13;
  localparam logic [KindBits-1:0] TkGreater = 6'd15;
  localparam logic [KindBits-1:0] TkLess    = 6'd17;
  localparam logic [KindBits-1:0] TkIdent   = 6'd19;
  localparam logic [KindBits-1:0] TkString  = 6'd20;
  localparam logic [KindBits-1:0] TkNumber  = 6'd21;
  localparam logic [KindBits-1:0] TkError   = 6'd38;
  localparam logic [KindBits-1:0] TkEof     = 6'd39;

  localparam logic ErrUnexpected = 1'b0;
  localparam logic ErrUnterminated = 1'b1;

  typedef enum logic [7:0] {
    ModeIdle = 8'b0000_0001,
    ModeWord = 8'b0000_0010,
    ModeInt  = 8'b0000_0100,
    ModeDot  = 8'b0000_1000,
    ModeFrac = 8'b0001_0000,
    ModeStr  = 8'b0010_0000,
    ModeOp   = 8'b0100_0000,
    ModeNote = 8'b1000_0000
  } scan_mode_e;

  // One classified input beat as handed from front to back.
  typedef struct packed {
    logic                  is_end;
    logic [7:0]            char_code;
    logic                  is_letter;
    logic                  is_digit;
    logic                  is_blank;
    logic                  is_newline;
    logic                  is_quote;
    logic                  is_dot;
    logic                  is_equal;
    logic                  is_slash;
    logic                  is_opener;
    logic                  is_single;
    logic [KindBits-1:0]   single_kind;
    logic [OffsetBits-1:0] offset;
  } class_t;

  typedef struct packed {
    logic [KindBits-1:0]  kind;
    logic                 err;
    logic [FieldBits-1:0] start;
    logic [FieldBits-1:0] len;
    logic [FieldBits-1:0] line;
    logic                 last;
  } token_t;

  function automatic logic [KindBits-1:0] lone_op(input logic [7:0] c);
    unique case (c)
      8'h21:   lone_op = TkBang;
      8'h3D:   lone_op = TkEqual;
      8'h3C:   lone_op = TkLess;
      8'h3E:   lone_op = TkGreater;
      default: lone_op = TkSlash;
    endcase
  endfunction

  function automatic logic [KindBits-1:0] single_kind_of(input logic [7:0] c,
                                                         output logic hit);
    hit = 1'b1;
    unique case (c)
      8'h28:   single_kind_of = 6'd0;
      8'h29:   single_kind_of = 6'd1;
      8'h7B:   single_kind_of = 6'd2;
      8'h7D:   single_kind_of = 6'd3;
      8'h2C:   single_kind_of = 6'd4;
      8'h2E:   single_kind_of = 6'd5;
      8'h2D:   single_kind_of = 6'd6;
      8'h2B:   single_kind_of = 6'd7;
      8'h3B:   single_kind_of = 6'd8;
      8'h2A:   single_kind_of = 6'd10;
      default: begin
        hit = 1'b0;
        single_kind_of = TkError;
      end
    endcase
  endfunction

  function automatic logic [KindBits-1:0] word_kind(input logic [47:0] w,
                                                    input logic [2:0] n);
    logic [KindBits-1:0] k;
    k = TkIdent;
    unique case (n)
      3'd2: begin
        if (w[15:0] == "fi") k = 6'd28;
        else if (w[15:0] == "ro") k = 6'd30;
      end
      3'd3: begin
        if (w[23:0] == "dna") k = 6'd22;
        else if (w[23:0] == "rof") k = 6'd26;
        else if (w[23:0] == "nuf") k = 6'd27;
        else if (w[23:0] == "lin") k = 6'd29;
        else if (w[23:0] == "rav") k = 6'd36;
      end
      3'd4: begin
        if (w[31:0] == "esle") k = 6'd24;
        else if (w[31:0] == "siht") k = 6'd34;
        else if (w[31:0] == "eurt") k = 6'd35;
      end
      3'd5: begin
        if (w[39:0] == "ssalc") k = 6'd23;
        else if (w[39:0] == "eslaf") k = 6'd25;
        else if (w[39:0] == "tnirp") k = 6'd31;
        else if (w[39:0] == "repus") k = 6'd33;
        else if (w[39:0] == "elihw") k = 6'd37;
      end
      3'd6: begin
        if (w[47:0] == "nruter") k = 6'd32;
      end
      default: k = TkIdent;
    endcase
    return k;
  endfunction
endpackage
`default_nettype wire

FILE: rtl/ktl_stream_if.sv
// Valid/ready stream interface carrying one payload beat.
`default_nettype none
interface ktl_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: rtl/ktl_in_t.sv
// Input beat type of the lexer.
`default_nettype none
package ktl_in_pkg;
  typedef struct packed {
    logic       kind;
    logic [7:0] char_code;
  } ktl_in_t;
endpackage
`default_nettype wire

FILE: rtl/ktl_front.sv
// Front end: accepts characters, classifies them and stamps their offset.
`default_nettype none
module ktl_front
  import ktl_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   in_valid_i,
  output logic        in_ready_o,
  input  wire logic   in_kind_i,
  input  wire logic [7:0] in_char_i,
  output logic        q_valid_o,
  input  wire logic   q_ready_i,
  output class_t      q_data_o
);
  logic [OffsetBits-1:0] offset_q, offset_d;
  logic                  valid_q;
  class_t                data_q, cls;
  logic                  hit;
  logic                  take;
  logic [7:0]            c;

  assign c = in_char_i;
  assign in_ready_o = !valid_q || q_ready_i;
  assign take = in_valid_i && in_ready_o;
  assign q_valid_o = valid_q;
  assign q_data_o = data_q;

  always_comb begin
    cls.is_end     = in_kind_i;
    cls.char_code  = c;
    cls.is_letter  = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
    cls.is_digit   = c >= 8'h30 && c <= 8'h39;
    cls.is_blank   = c == 8'h20 || c == 8'h0D || c == 8'h09;
    cls.is_newline = c == 8'h0A;
    cls.is_quote   = c == 8'h22;
    cls.is_dot     = c == 8'h2E;
    cls.is_equal   = c == 8'h3D;
    cls.is_slash   = c == 8'h2F;
    cls.is_opener  = c == 8'h21 || c == 8'h3D || c == 8'h3C || c == 8'h3E || c == 8'h2F;
    cls.single_kind = single_kind_of(c, hit);
    cls.is_single  = hit;
    cls.offset     = offset_q;
  end

  always_comb begin
    offset_d = offset_q;
    if (take) begin
      if (in_kind_i) offset_d = '0;
      else if (offset_q != OffTop) offset_d = offset_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      valid_q  <= 1'b0;
    end else begin
      offset_q <= offset_d;
      if (in_ready_o) valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) data_q <= cls;
  end
endmodule
`default_nettype wire

FILE: rtl/ktl_back.sv
// Back end: scan state machine producing up to three tokens per beat.
`default_nettype none
module ktl_back
  import ktl_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   q_valid_i,
  output logic        q_ready_o,
  input  wire class_t q_data_i,
  output logic        out_valid_o,
  input  wire logic   out_ready_i,
  output token_t      out_data_o
);
  scan_mode_e            mode_q, mode_d;
  logic [7:0]            held_q, held_d;
  logic [OffsetBits-1:0] begin_q, begin_d;
  logic [LineBits-1:0]   line_q, line_d;
  logic [47:0]           word_q, word_d;

  token_t                tok [3];
  token_t                slot_q [3];
  logic [1:0]            cnt, cnt_q, idx_q;
  logic                  busy_q;
  logic                  fire;

  class_t                ci;
  logic [OffsetBits-1:0] p, span, dot_at;
  logic                  restart;

  assign ci = q_data_i;
  assign p  = ci.offset;
  assign span = p - begin_q;
  assign dot_at = (p > begin_q) ? p - 1'b1 : p;

  function automatic token_t mk(input logic [KindBits-1:0] k, input logic e,
                                input logic [OffsetBits-1:0] s,
                                input logic [OffsetBits-1:0] l,
                                input logic [LineBits-1:0] ln);
    token_t t;
    t.kind  = k;
    t.err   = e;
    t.start = FieldBits'(s);
    t.len   = FieldBits'(l);
    t.line  = FieldBits'(ln);
    t.last  = 1'b0;
    return t;
  endfunction

  // Hand off a queued beat only once all tokens of the previous beat are gone or the last is being taken.
  assign q_ready_o = !busy_q || (out_ready_i && (idx_q + 1'b1 == cnt_q));
  assign fire = q_valid_i && q_ready_o;

  always_comb begin
    logic                  do_close;
    logic [LineBits-1:0]   ln;
    mode_d  = mode_q;
    held_d  = held_q;
    begin_d = begin_q;
    line_d  = line_q;
    word_d  = word_q;
    cnt     = 2'd0;
    restart = 1'b0;
    do_close = 1'b0;
    tok[0] = mk(TkEof, 1'b0, '0, '0, line_q);
    tok[1] = tok[0];
    tok[2] = tok[0];
    ln = line_q;

    if (ci.is_end) begin
      if (mode_q == ModeStr) begin
        tok[0] = mk(TkError, ErrUnterminated, begin_q, span, ln);
        cnt = 2'd1;
      end else begin
        do_close = 1'b1;
      end
    end else begin
      unique case (mode_q)
        ModeWord: begin
          if (ci.is_letter || ci.is_digit) begin
            if (span < 6) begin
              word_d[8*span[2:0] +: 8] = ci.char_code;
            end
          end else do_close = 1'b1;
        end
        ModeInt: begin
          if (ci.is_dot) mode_d = ModeDot;
          else if (!ci.is_digit) do_close = 1'b1;
        end
        ModeDot: begin
          if (ci.is_digit) mode_d = ModeFrac;
          else do_close = 1'b1;
        end
        ModeFrac: begin
          if (!ci.is_digit) do_close = 1'b1;
        end
        ModeStr: begin
          if (ci.is_quote) begin
            tok[0] = mk(TkString, 1'b0, begin_q, span + 1'b1, ln);
            cnt = 2'd1;
            mode_d = ModeIdle;
          end else if (ci.is_newline && line_q != LineTop) begin
            line_d = line_q + 1'b1;
          end
        end
        ModeOp: begin
          if (held_q == 8'h2F && ci.is_slash) mode_d = ModeNote;
          else if (held_q != 8'h2F && ci.is_equal) begin
            tok[0] = mk(lone_op(held_q) + 1'b1, 1'b0, begin_q, OffsetBits'(2), ln);
            cnt = 2'd1;
            mode_d = ModeIdle;
          end else do_close = 1'b1;
        end
        ModeNote: begin
          if (ci.is_newline) begin
            mode_d = ModeIdle;
            if (line_q != LineTop) line_d = line_q + 1'b1;
          end
        end
        default: do_close = 1'b1;
      endcase
    end

    if (do_close) begin
      mode_d = ModeIdle;
      unique case (mode_q)
        ModeWord: begin
          tok[0] = mk((span > 6) ? TkIdent : word_kind(word_q, span[2:0]),
                      1'b0, begin_q, span, ln);
          cnt = 2'd1;
        end
        ModeInt, ModeFrac: begin
          tok[0] = mk(TkNumber, 1'b0, begin_q, span, ln);
          cnt = 2'd1;
        end
        ModeDot: begin
          tok[0] = mk(TkNumber, 1'b0, begin_q, dot_at - begin_q, ln);
          tok[1] = mk(TkDot, 1'b0, dot_at, OffsetBits'(1), ln);
          cnt = 2'd2;
        end
        ModeOp: begin
          tok[0] = mk(lone_op(held_q), 1'b0, begin_q, OffsetBits'(1), ln);
          cnt = 2'd1;
        end
        default: cnt = 2'd0;
      endcase
      if (!ci.is_end) begin
        // Start the next token from this character.
        if (ci.is_blank) begin
        end else if (ci.is_newline) begin
          if (line_q != LineTop) line_d = line_q + 1'b1;
        end else begin
          begin_d = p;
          if (ci.is_letter) begin
            mode_d = ModeWord;
            word_d = {40'd0, ci.char_code};
          end else if (ci.is_digit) mode_d = ModeInt;
          else if (ci.is_quote) mode_d = ModeStr;
          else if (ci.is_opener) begin
            mode_d = ModeOp;
            held_d = ci.char_code;
          end else begin
            tok[cnt] = mk(ci.is_single ? ci.single_kind : TkError, ErrUnexpected,
                          p, OffsetBits'(1), line_q);
            cnt = cnt + 2'd1;
          end
        end
      end
    end

    if (ci.is_end) begin
      tok[cnt] = mk(TkEof, 1'b0, p, '0, line_q);
      cnt = cnt + 2'd1;
      restart = 1'b1;
    end
    if (cnt != 2'd0) tok[cnt - 2'd1].last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeIdle;
      held_q  <= '0;
      begin_q <= '0;
      line_q  <= LineBits'(1);
      word_q  <= '0;
      busy_q  <= 1'b0;
      cnt_q   <= '0;
      idx_q   <= '0;
    end else begin
      if (fire) begin
        if (restart) begin
          mode_q  <= ModeIdle;
          held_q  <= '0;
          begin_q <= '0;
          line_q  <= LineBits'(1);
          word_q  <= '0;
        end else begin
          mode_q  <= mode_d;
          held_q  <= held_d;
          begin_q <= begin_d;
          line_q  <= line_d;
          word_q  <= word_d;
        end
        busy_q <= cnt != 2'd0;
        cnt_q  <= cnt;
        idx_q  <= '0;
      end else if (busy_q && out_ready_i) begin
        if (idx_q + 1'b1 == cnt_q) busy_q <= 1'b0;
        else idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      slot_q[0] <= tok[0];
      slot_q[1] <= tok[1];
      slot_q[2] <= tok[2];
    end
  end

  assign out_valid_o = busy_q;
  assign out_data_o  = slot_q[idx_q];
endmodule
`default_nettype wire

FILE: rtl/keyword_token_lexer.sv
// Top level of the keyword token lexer.
// Usage:
//  - in_i carries beats {kind, char_code}: kind 0 is a source character,
//    kind 1 closes the source, flushes pending tokens and emits end of file.
//  - out_o carries tokens {token_kind, error_code, start_offset,
//    token_length, line_number, last}; last marks the final token of a beat.
//  - A beat is registered in the front end, then its tokens in the back end;
//    tokens needing lookahead complete with the following character.
//  - Throughput: one character per cycle while the receiver takes tokens
//    and each beat yields at most one token; a beat yielding more holds the
//    back end until all have left the single token output register bank.
//  - The front end registers each classified beat; it keeps accepting while
//    the back end waits on the receiver, until that register is full.
//  - Reset: line count 1, offset 0, scanner between tokens.
//  - A stalled receiver holds the current token and backs up both ends.
`default_nettype none
module keyword_token_lexer
  import ktl_pkg::*;
  import ktl_in_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  ktl_stream_if.sink   in_i,
  ktl_stream_if.source out_o
);
  logic   qv, qr;
  class_t qd;
  ktl_in_t ib;
  token_t ob;

  assign ib = in_i.payload;

  ktl_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(in_i.valid), .in_ready_o(in_i.ready),
    .in_kind_i(ib.kind), .in_char_i(ib.char_code),
    .q_valid_o(qv), .q_ready_i(qr), .q_data_o(qd)
  );

  ktl_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i(qv), .q_ready_o(qr), .q_data_i(qd),
    .out_valid_o(out_o.valid), .out_ready_i(out_o.ready), .out_data_o(ob)
  );

  assign out_o.payload = ob;
endmodule
`default_nettype wire

FILE: rtl/ktl_checker.sv
// Port-level checker for the keyword token lexer, bound to the top level.
`default_nettype none
module ktl_checker
  import ktl_pkg::*;
(
  input wire logic   clk_i,
  input wire logic   rst_ni,
  input wire logic   out_valid,
  input wire logic   out_ready,
  input wire token_t out_payload
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_payload))
    else $error("token changed under stall");
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_payload.kind <= TkEof)
    else $error("token kind out of range");
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_payload.err |-> out_payload.kind == TkError)
    else $error("error code on non-error token");
  a_eof: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_payload.kind == TkEof |-> out_payload.last && out_payload.len == '0)
    else $error("bad eof token");
endmodule

bind keyword_token_lexer ktl_checker u_ktl_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .out_valid(out_o.valid), .out_ready(out_o.ready), .out_payload(out_o.payload)
);
`default_nettype wire

FILE: verif/keyword_token_lexer_tb.sv
// Testbench for keyword_token_lexer: directed and random character streams checked against a token predictor.
`timescale 1ns / 1ps
module keyword_token_lexer_tb;
  import ktl_pkg::*;
  import ktl_in_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned QuietTail  = 30;
  localparam logic KindChar = 1'b0;
  localparam logic KindEnd  = 1'b1;
  localparam logic [KindBits-1:0] TkLParen = 6'd0;
  localparam logic [KindBits-1:0] TkRParen = 6'd1;
  localparam logic [KindBits-1:0] TkLBrace = 6'd2;
  localparam logic [KindBits-1:0] TkRBrace = 6'd3;
  localparam logic [KindBits-1:0] TkComma  = 6'd4;
  localparam logic [KindBits-1:0] TkMinus  = 6'd6;
  localparam logic [KindBits-1:0] TkPlus   = 6'd7;
  localparam logic [KindBits-1:0] TkSemi   = 6'd8;
  localparam logic [KindBits-1:0] TkStar   = 6'd10;
  localparam logic [KindBits-1:0] TkFirstKeyword = 6'd22;

  typedef struct {
    ktl_in_t beat;
    bit      drain;
  } pending_beat_t;

  logic clk_i;
  logic rst_ni;

  ktl_stream_if #(.payload_t(ktl_in_t)) in_if ();
  ktl_stream_if #(.payload_t(token_t))  out_if ();

  keyword_token_lexer u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  pending_beat_t char_queue[$];
  token_t        token_queue[$];
  token_t        beat_tokens[$];
  int unsigned   errors;
  int unsigned   cycles;
  int unsigned   send_gap;
  int unsigned   recv_gap;
  bit            quiet;

  string keywords[16] = '{"and", "class", "else", "false", "for", "fun", "if", "nil",
                          "or", "print", "return", "super", "this", "true", "var", "while"};

  scan_mode_e  lex_mode;
  logic [7:0]  lex_held;
  logic [23:0] lex_begin;
  logic [23:0] lex_offset;
  logic [23:0] lex_line;
  logic [47:0] lex_prefix;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [KindBits-1:0] operator_kind(logic [7:0] c);
    case (c)
      "!":     return TkBang;
      "=":     return TkEqual;
      "<":     return TkLess;
      ">":     return TkGreater;
      default: return TkSlash;
    endcase
  endfunction

  function automatic logic [KindBits-1:0] word_token(logic [23:0] n);
    string s;
    bit    same;
    for (int i = 0; i < 16; i++) begin
      s = keywords[i];
      same = (n == s.len());
      for (int k = 0; same && k < s.len(); k++)
        if (lex_prefix[8*k +: 8] != s[k]) same = 1'b0;
      if (same) return KindBits'(TkFirstKeyword + i);
    end
    return TkIdent;
  endfunction

  function automatic void add_token(logic [KindBits-1:0] k, logic e, logic [23:0] s,
                                    logic [23:0] n);
    token_t t;
    t.kind = k; t.err = e; t.start = s; t.len = n; t.line = lex_line; t.last = 1'b0;
    if (beat_tokens.size() < 3) beat_tokens.push_back(t);
  endfunction

  function automatic void bump_line();
    if (lex_line != LineTop) lex_line++;
  endfunction

  function automatic void close_token(logic [23:0] p);
    logic [23:0] dot_at;
    case (lex_mode)
      ModeWord: add_token(word_token(p - lex_begin), 1'b0, lex_begin, p - lex_begin);
      ModeInt, ModeFrac: add_token(TkNumber, 1'b0, lex_begin, p - lex_begin);
      ModeDot: begin
        dot_at = (p > lex_begin) ? p - 24'd1 : p;
        add_token(TkNumber, 1'b0, lex_begin, dot_at - lex_begin);
        add_token(TkDot, 1'b0, dot_at, 24'd1);
      end
      ModeOp: add_token(operator_kind(lex_held), 1'b0, lex_begin, 24'd1);
      default: ;
    endcase
    lex_mode = ModeIdle;
  endfunction

  function automatic void open_token(logic [7:0] c, logic [23:0] p);
    if (c == " " || c == 8'h0d || c == 8'h09) return;
    if (c == 8'h0a) begin
      bump_line();
      return;
    end
    lex_begin = p;
    if (is_alpha(c)) begin
      lex_mode = ModeWord;
      lex_prefix = {40'd0, c};
    end else if (is_digit(c)) begin
      lex_mode = ModeInt;
    end else if (c == "\"") begin
      lex_mode = ModeStr;
    end else if (c == "!" || c == "=" || c == "<" || c == ">" || c == "/") begin
      lex_mode = ModeOp;
      lex_held = c;
    end else begin
      case (c)
        "(": add_token(TkLParen, 1'b0, p, 24'd1);
        ")": add_token(TkRParen, 1'b0, p, 24'd1);
        "{": add_token(TkLBrace, 1'b0, p, 24'd1);
        "}": add_token(TkRBrace, 1'b0, p, 24'd1);
        ",": add_token(TkComma, 1'b0, p, 24'd1);
        ".": add_token(TkDot, 1'b0, p, 24'd1);
        "-": add_token(TkMinus, 1'b0, p, 24'd1);
        "+": add_token(TkPlus, 1'b0, p, 24'd1);
        ";": add_token(TkSemi, 1'b0, p, 24'd1);
        "*": add_token(TkStar, 1'b0, p, 24'd1);
        default: add_token(TkError, ErrUnexpected, p, 24'd1);
      endcase
    end
  endfunction

  function automatic void lexer_clear();
    lex_mode = ModeIdle; lex_held = '0; lex_begin = '0;
    lex_offset = '0; lex_line = 24'd1; lex_prefix = '0;
  endfunction

  function automatic void lex_beat(ktl_in_t b);
    logic [7:0]  c;
    logic [23:0] p;
    c = b.char_code;
    p = lex_offset;
    beat_tokens.delete();
    if (b.kind == KindEnd) begin
      if (lex_mode == ModeStr) add_token(TkError, ErrUnterminated, lex_begin, p - lex_begin);
      else close_token(p);
      add_token(TkEof, 1'b0, p, 24'd0);
      lexer_clear();
    end else begin
      case (lex_mode)
        ModeWord: begin
          if (is_alpha(c) || is_digit(c)) begin
            if (p - lex_begin < 6) lex_prefix[8*(p - lex_begin) +: 8] = c;
          end else begin
            close_token(p);
            open_token(c, p);
          end
        end
        ModeInt: begin
          if (c == ".") lex_mode = ModeDot;
          else if (!is_digit(c)) begin
            close_token(p);
            open_token(c, p);
          end
        end
        ModeDot: begin
          if (is_digit(c)) lex_mode = ModeFrac;
          else begin
            close_token(p);
            open_token(c, p);
          end
        end
        ModeFrac: begin
          if (!is_digit(c)) begin
            close_token(p);
            open_token(c, p);
          end
        end
        ModeStr: begin
          if (c == "\"") begin
            add_token(TkString, 1'b0, lex_begin, p + 24'd1 - lex_begin);
            lex_mode = ModeIdle;
          end else if (c == 8'h0a) bump_line();
        end
        ModeOp: begin
          if (lex_held == "/" && c == "/") lex_mode = ModeNote;
          else if (lex_held != "/" && c == "=") begin
            add_token(operator_kind(lex_held) + 6'd1, 1'b0, lex_begin, 24'd2);
            lex_mode = ModeIdle;
          end else begin
            close_token(p);
            open_token(c, p);
          end
        end
        ModeNote: begin
          if (c == 8'h0a) begin
            lex_mode = ModeIdle;
            bump_line();
          end
        end
        default: begin
          lex_mode = ModeIdle;
          open_token(c, p);
        end
      endcase
      if (lex_offset != OffTop) lex_offset++;
    end
    if (beat_tokens.size() > 0) beat_tokens[beat_tokens.size()-1].last = 1'b1;
    foreach (beat_tokens[i]) token_queue.push_back(beat_tokens[i]);
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  task automatic push_char(logic [7:0] c, bit drain = 1'b0);
    pending_beat_t e;
    e.beat.kind = KindChar; e.beat.char_code = c; e.drain = drain;
    char_queue.push_back(e);
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
  endtask

  task automatic push_end(bit drain = 1'b0);
    pending_beat_t e;
    e.beat.kind = KindEnd; e.beat.char_code = 8'($urandom); e.drain = drain;
    char_queue.push_back(e);
  endtask

  task automatic push_lexeme();
    string ops[19] = '{"!=", "==", "<=", ">=", "!", "=", "<", ">", "/", "(", ")", "{", "}",
                       ",", ".", "-", "+", ";", "*"};
    string alnum = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    string seps = " \t\r\n";
    int n;
    case ($urandom_range(0, 19))
      0, 1, 2, 3: push_text(keywords[$urandom_range(0, 15)]);
      4, 5, 6: begin
        push_char(alnum[$urandom_range(0, 52)]);
        n = $urandom_range(0, 8);
        repeat (n) push_char(alnum[$urandom_range(0, 62)]);
      end
      7, 8: begin
        repeat ($urandom_range(1, 4)) push_char(8'("0" + $urandom_range(0, 9)));
        if ($urandom_range(0, 1)) begin
          push_char(".");
          repeat ($urandom_range(0, 3)) push_char(8'("0" + $urandom_range(0, 9)));
        end
      end
      9, 10: begin
        push_char("\"");
        repeat ($urandom_range(0, 6))
          push_char($urandom_range(0, 4) == 0 ? 8'h0a : 8'($urandom_range(32, 126)));
        if ($urandom_range(0, 5) != 0) push_char("\"");
      end
      11, 12, 13, 14: push_text(ops[$urandom_range(0, 18)]);
      15: begin
        push_text("//");
        repeat ($urandom_range(0, 5)) push_char(8'($urandom_range(32, 126)));
        push_char(8'h0a);
      end
      16, 17: push_char(8'($urandom_range(1, 255)));
      18: push_end();
      default: ;
    endcase
    if ($urandom_range(0, 2) != 0) push_char(seps[$urandom_range(0, 3)]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pending_beat_t sent;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.payload <= '0;
      send_gap <= 0;
    end else if (in_if.valid && !in_if.ready) begin
      in_if.valid <= 1'b1;
    end else begin
      if (in_if.valid) begin
        sent = char_queue.pop_front();
        lex_beat(sent.beat);
      end
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_if.valid <= 1'b0;
      end else if (char_queue.size() > 0 &&
                   !(char_queue[0].drain && token_queue.size() != 0)) begin
        in_if.valid <= 1'b1;
        in_if.payload <= char_queue[0].beat;
        if (!quiet && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 11);
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    token_t got;
    token_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      recv_gap <= 0;
      cycles <= 0;
    end else begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
        $display("keyword_token_lexer_tb failed");
        $finish;
      end
      if (out_if.valid && out_if.ready) begin
        got = out_if.payload;
        if (token_queue.size() == 0) begin
          report("unexpected token kind", got.kind, -1);
        end else begin
          want = token_queue.pop_front();
          if (got.kind != want.kind) report("token_kind", got.kind, want.kind);
          if (got.err != want.err) report("error_code", got.err, want.err);
          if (got.start != want.start) report("start_offset", got.start, want.start);
          if (got.len != want.len) report("token_length", got.len, want.len);
          if (got.line != want.line) report("line_number", got.line, want.line);
          if (got.last != want.last) report("last", got.last, want.last);
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_if.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
        recv_gap <= $urandom_range(1, 11) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    errors = 0;
    quiet = 1'b0;
    lexer_clear();
    rst_ni = 1'b0;

    push_text("and classy returns(x)>=!=");
    push_char(8'h0a);
    push_text("12.x 3.5. \"ab");
    push_char(8'h0a);
    push_char(8'd1);
    push_char(8'd255);
    push_text("// c");
    push_char(8'h0a);
    push_text("</\"q");
    push_end();
    push_text("while");
    push_end(1'b1);
    while (char_queue.size() < 110) push_lexeme();
    push_char("!", 1'b1);
    repeat (20) push_lexeme();
    push_end();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (char_queue.size() < QuietTail);
    quiet = 1'b1;
    wait (char_queue.size() == 0 && !in_if.valid);
    wait (token_queue.size() == 0);
    repeat (20) @(posedge clk_i);
    if (errors == 0 && token_queue.size() == 0) begin
      $display("keyword_token_lexer_tb passed");
    end else begin
      $display("keyword_token_lexer_tb failed");
    end
    $finish;
  end
endmodule
